// File: rtl/hgl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgl_pkg
// Shared types for the tournament branch predictor.
// ----------------------------------------------------------------------------
package hgl_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_WRITE,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear;      // write zero at clear address
    logic clear_step; // advance clear address
    logic load;       // capture input beat, issue history/chooser read
    logic read_ctr;   // issue counter reads
    logic calc;       // evaluate predictions
    logic write;      // write back all stores
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
  } status_t;

endpackage

// File: rtl/hgl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgl_ram
// Single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hgl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/hgl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgl_ctrl
// Sequencer: clearing pass, then read, evaluate, write back, deliver.
// ----------------------------------------------------------------------------
module hgl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output hgl_pkg::cmd_t    cmd,
  input  hgl_pkg::status_t status
);
  import hgl_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (status.clear_done) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = ST_READ;
      ST_READ:  state_next = ST_CALC;
      ST_CALC:  state_next = ST_WRITE;
      ST_WRITE: state_next = ST_OUT;
      ST_OUT: begin
        if (!out_stall) state_next = in_valid ? ST_READ : ST_IDLE;
      end
      default:  state_next = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear      = 1'b1;
        cmd.clear_step = 1'b1;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_READ:  cmd.read_ctr = 1'b1;
      ST_CALC:  cmd.calc = 1'b1;
      ST_WRITE: cmd.write = 1'b1;
      ST_OUT: begin
        out_valid = 1'b1;
        in_stall  = out_stall;
        cmd.load  = in_valid && !out_stall;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/hgl_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgl_datapath
// Predictor stores, global history, counter evaluation and update.
// ----------------------------------------------------------------------------
module hgl_datapath #(
  parameter int INDEX_BITS       = 12,
  parameter int MAX_COUNTER_BITS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [3:0]       cfg_wdata,
  input  logic [31:0]      branch_address,
  input  logic             taken,
  input  hgl_pkg::cmd_t    cmd,
  output hgl_pkg::status_t status,
  output logic             predict_taken,
  output logic             prediction_correct,
  output logic             chose_local,
  output logic             gshare_correct,
  output logic             local_correct
);
  import hgl_pkg::*;

  localparam int DEPTH = 1 << INDEX_BITS;
  localparam int CW    = MAX_COUNTER_BITS;

  logic [3:0]            counter_bits;
  logic [INDEX_BITS-1:0] global_history;
  logic [INDEX_BITS-1:0] clear_addr;
  logic                  clear_last;
  logic [INDEX_BITS-1:0] low;
  logic                  t;
  logic [INDEX_BITS-1:0] gidx, lidx;
  logic [INDEX_BITS-1:0] lhist_rd;
  logic                  chooser_rd;
  logic [CW-1:0]         gctr_rd, lctr_rd;
  logic [CW-1:0]         gctr_new, lctr_new;
  logic [CW-1:0]         maxv, half;
  logic                  gpred, lpred, use_local;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      counter_bits <= 4'd2;
    end else if (cfg_we) begin
      counter_bits <= cfg_wdata;
    end
  end

  // clamp width, derive max and threshold
  always_comb begin
    logic [3:0] n;
    n = counter_bits;
    if (n == 4'd0) n = 4'd1;
    if (32'(n) > CW) n = 4'(CW);
    maxv = CW'(({(CW+1){1'b0}} | ((CW+1)'(1) << n)) - (CW+1)'(1));
    half = CW'((CW+1)'(1) << (n - 4'd1));
  end

  // clearing pass address
  assign clear_last        = (clear_addr == {INDEX_BITS{1'b1}});
  assign status.clear_done = clear_last;
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_step) begin
      clear_addr <= clear_addr + 1'b1;
    end
  end

  // input capture and global history
  always_ff @(posedge clk) begin
    if (rst) begin
      global_history <= '0;
    end else if (cmd.write) begin
      global_history <= {global_history[INDEX_BITS-2:0], t};
    end
    if (cmd.load) begin
      low  <= branch_address[INDEX_BITS-1:0];
      t    <= taken;
      gidx <= branch_address[INDEX_BITS-1:0] ^ global_history;
    end
    if (cmd.read_ctr) begin
      lidx <= lhist_rd;
    end
  end

  // stores
  hgl_ram #(.WIDTH(INDEX_BITS), .DEPTH(DEPTH)) u_lhist (
    .clk(clk), .we(cmd.clear || cmd.write),
    .waddr(cmd.clear ? clear_addr : low),
    .wdata(cmd.clear ? '0 : {lidx[INDEX_BITS-2:0], t}),
    .raddr(branch_address[INDEX_BITS-1:0]), .rdata(lhist_rd)
  );

  hgl_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_chooser (
    .clk(clk), .we(cmd.clear || cmd.write),
    .waddr(cmd.clear ? clear_addr : low),
    .wdata(cmd.clear ? 1'b0 : (!gshare_correct && local_correct)),
    .raddr(branch_address[INDEX_BITS-1:0]), .rdata(chooser_rd)
  );

  hgl_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_gctr (
    .clk(clk), .we(cmd.clear || cmd.write),
    .waddr(cmd.clear ? clear_addr : gidx),
    .wdata(cmd.clear ? '0 : gctr_new),
    .raddr(gidx), .rdata(gctr_rd)
  );

  hgl_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_lctr (
    .clk(clk), .we(cmd.clear || cmd.write),
    .waddr(cmd.clear ? clear_addr : lidx),
    .wdata(cmd.clear ? '0 : lctr_new),
    .raddr(lhist_rd), .rdata(lctr_rd)
  );

  // chooser read is held until evaluation
  always_ff @(posedge clk) begin
    if (cmd.read_ctr) begin
      use_local <= chooser_rd;
    end
  end

  assign gpred = (gctr_rd >= half);
  assign lpred = (lctr_rd >= half);

  // evaluation and counter update
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      gshare_correct     <= (gpred == t);
      local_correct      <= (lpred == t);
      chose_local        <= use_local;
      predict_taken      <= use_local ? lpred : gpred;
      prediction_correct <= (use_local ? lpred : gpred) == t;
      if (t) begin
        gctr_new <= (gctr_rd >= maxv) ? maxv : gctr_rd + 1'b1;
        lctr_new <= (lctr_rd >= maxv) ? maxv : lctr_rd + 1'b1;
      end else begin
        gctr_new <= (gctr_rd != '0) ? gctr_rd - 1'b1 : '0;
        lctr_new <= (lctr_rd != '0) ? lctr_rd - 1'b1 : '0;
      end
    end
  end

endmodule

// File: rtl/hybrid_gshare_local_predictor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hybrid_gshare_local_predictor
// Tournament predictor: gshare and local-history components, 1-bit chooser.
// ----------------------------------------------------------------------------
// After an input beat is taken the read, evaluate and write-back states run
// before the result is offered; a new branch is taken only once it is offered,
// as the history read, counter read and read-modify-write of the counter RAMs
// depend on each other. Reset: after rst a clearing pass zeroes all tables;
// no input beat is taken during it. counter_bits resets to 2.
module hybrid_gshare_local_predictor #(
  parameter int INDEX_BITS       = 12,
  parameter int MAX_COUNTER_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] branch_address,
  input  logic        taken,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        predict_taken,
  output logic        prediction_correct,
  output logic        chose_local,
  output logic        gshare_correct,
  output logic        local_correct
);
  import hgl_pkg::*;

  cmd_t    cmd;
  status_t status;

  hgl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .status(status)
  );

  hgl_datapath #(
    .INDEX_BITS(INDEX_BITS), .MAX_COUNTER_BITS(MAX_COUNTER_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .branch_address(branch_address), .taken(taken), .cmd(cmd), .status(status),
    .predict_taken(predict_taken), .prediction_correct(prediction_correct),
    .chose_local(chose_local), .gshare_correct(gshare_correct),
    .local_correct(local_correct)
  );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tournament branch predictor. Branch beats are
// driven in random bursts, each one run through a behavioural predictor with
// its own tables, and every result beat is compared field by field with the
// oldest expected outcome. counter_bits is stepped through a spread of
// widths, out-of-range values included.
// ----------------------------------------------------------------------------
module testbench;

  localparam int IDX_W   = 12;
  localparam int TBL_SZ  = 1 << IDX_W;
  localparam int MAX_W   = 8;
  localparam int LIMIT   = 400000;
  localparam int NPHASE  = 7;

  typedef struct packed {
    logic [31:0] addr;
    logic        tkn;
  } branch_t;

  typedef struct packed {
    logic pred;
    logic pred_ok;
    logic use_loc;
    logic g_ok;
    logic l_ok;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] branch_address = '0;
  logic        taken = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        predict_taken, prediction_correct, chose_local;
  logic        gshare_correct, local_correct;

  hybrid_gshare_local_predictor uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .branch_address(branch_address), .taken(taken),
    .out_valid(out_valid), .out_stall(out_stall),
    .predict_taken(predict_taken), .prediction_correct(prediction_correct),
    .chose_local(chose_local), .gshare_correct(gshare_correct),
    .local_correct(local_correct)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [7:0]       gsh_ctr [TBL_SZ];
  logic [7:0]       loc_ctr [TBL_SZ];
  logic [IDX_W-1:0] loc_hist [TBL_SZ];
  logic             chooser [TBL_SZ];
  logic [IDX_W-1:0] glob_hist;
  logic [3:0]       ctr_width_reg;

  branch_t  branch_q [$];
  verdict_t verdict_q [$];
  int errors = 0;
  int n_checked = 0;
  int cycles = 0;
  bit hold_sender = 1'b0;
  bit long_stall_req = 1'b0;

  function automatic logic [7:0] bump(logic [7:0] c, logic t, int unsigned maxv);
    if (t) return (c >= maxv) ? 8'(maxv) : c + 8'd1;
    return (c > 0) ? c - 8'd1 : 8'd0;
  endfunction

  // work out the verdict for one branch and update the tables
  function automatic verdict_t resolve_branch(branch_t b);
    int unsigned w, maxv, half;
    logic [IDX_W-1:0] low, gi, li;
    logic gp, lp;
    verdict_t v;
    w = (ctr_width_reg < 1) ? 1 : (ctr_width_reg > MAX_W) ? MAX_W : ctr_width_reg;
    maxv = (1 << w) - 1;
    half = 1 << (w - 1);
    low = b.addr[IDX_W-1:0];
    gi = low ^ glob_hist;
    li = loc_hist[low];
    gp = gsh_ctr[gi] >= half;
    lp = loc_ctr[li] >= half;
    v.use_loc = chooser[low];
    v.pred = v.use_loc ? lp : gp;
    v.pred_ok = v.pred == b.tkn;
    v.g_ok = gp == b.tkn;
    v.l_ok = lp == b.tkn;
    gsh_ctr[gi] = bump(gsh_ctr[gi], b.tkn, maxv);
    loc_ctr[li] = bump(loc_ctr[li], b.tkn, maxv);
    glob_hist = {glob_hist[IDX_W-2:0], b.tkn};
    loc_hist[low] = {li[IDX_W-2:0], b.tkn};
    chooser[low] = !v.g_ok && v.l_ok;
    return v;
  endfunction

  task automatic report_mismatch(string what, logic got, logic want);
    $display("mismatch on %s at result %0d: got %0b expected %0b",
             what, n_checked, got, want);
    errors++;
  endtask

  // sample handshake at the rising edge, use it at the falling edge
  logic in_stall_s = 1'b0;
  always @(posedge clk) in_stall_s <= in_stall;

  // driver: bursts of beats with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall_s) begin
        verdict_q.push_back(resolve_branch(branch_q.pop_front()));
      end
      if (!in_valid || !in_stall_s) begin
        if (hold_sender || branch_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          branch_address <= branch_q[0].addr;
          taken <= branch_q[0].tkn;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
          end else begin
            burst_left--;
            if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ? 0 :
                                            $urandom_range(1, 12);
          end
        end
      end
    end
  end

  // receiver stall pattern, plus one long hold-off
  int stall_mode = 0;
  int long_left = 0;
  always @(negedge clk) begin
    if (long_stall_req && long_left == 0) long_left = 300;
    if (long_left > 0) begin
      long_left--;
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    verdict_t want;
    cycles++;
    if (!rst && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        report_mismatch("unexpected result beat", 1'b1, 1'b0);
      end else begin
        want = verdict_q.pop_front();
        if (predict_taken !== want.pred)
          report_mismatch("predict_taken", predict_taken, want.pred);
        if (prediction_correct !== want.pred_ok)
          report_mismatch("prediction_correct", prediction_correct, want.pred_ok);
        if (chose_local !== want.use_loc)
          report_mismatch("chose_local", chose_local, want.use_loc);
        if (gshare_correct !== want.g_ok)
          report_mismatch("gshare_correct", gshare_correct, want.g_ok);
        if (local_correct !== want.l_ok)
          report_mismatch("local_correct", local_correct, want.l_ok);
      end
      n_checked++;
    end
    if (cycles > LIMIT) begin
      $display("FAIL hybrid_gshare_local_predictor");
      $finish;
    end
  end

  function automatic branch_t rand_branch(int unsigned pool);
    branch_t b;
    b.addr = $urandom();
    // mostly a small set of loop-like branches so histories train
    if ($urandom_range(0, 3) != 0) b.addr[IDX_W-1:0] = IDX_W'($urandom_range(0, pool));
    b.tkn = ($urandom_range(0, 3) != 0);
    return b;
  endfunction

  task automatic drain();
    wait (branch_q.size() == 0 && !in_valid);
    wait (verdict_q.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_width(logic [3:0] w);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    ctr_width_reg = w;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  logic [3:0] widths [NPHASE] = '{4'd2, 4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd9};

  initial begin
    branch_t b;
    for (int i = 0; i < TBL_SZ; i++) begin
      gsh_ctr[i] = '0; loc_ctr[i] = '0; loc_hist[i] = '0; chooser[i] = 1'b0;
    end
    glob_hist = '0;
    ctr_width_reg = 4'd2;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: address extremes, both outcomes, a repeating pattern
    branch_q.push_back('{32'h0000_0000, 1'b1});
    branch_q.push_back('{32'hFFFF_FFFF, 1'b0});
    branch_q.push_back('{32'hFFFF_FFFF, 1'b1});
    branch_q.push_back('{32'h0000_0FFF, 1'b1});
    branch_q.push_back('{32'hAAAA_A555, 1'b0});
    branch_q.push_back('{32'h5555_5AAA, 1'b1});
    for (int i = 0; i < 16; i++) branch_q.push_back('{32'h0000_0040, 1'(i % 3 != 0)});
    drain();

    // random phases across counter widths
    for (int p = 0; p < NPHASE; p++) begin
      write_width(widths[p]);
      for (int i = 0; i < 200; i++) begin
        b = rand_branch(p[0] ? 15 : 255);
        branch_q.push_back(b);
      end
      if (p == 2) begin
        repeat (5) @(posedge clk);
        long_stall_req = 1'b1;
        @(posedge clk);
        long_stall_req = 1'b0;
      end
      if (p == 4) begin
        // pause mid-phase until every outstanding result is back
        wait (branch_q.size() <= 100);
        hold_sender = 1'b1;
        wait (!in_valid && verdict_q.size() == 0);
        repeat (20) @(posedge clk);
        hold_sender = 1'b0;
      end
      drain();
    end

    $display("checked %0d results over %0d counter widths incl. 0 and 15",
             n_checked, NPHASE);
    if (errors == 0) begin
      $display("PASS hybrid_gshare_local_predictor");
    end else begin
      $display("FAIL hybrid_gshare_local_predictor");
    end
    $finish;
  end

endmodule
